>>> design/ray_segment_pixel_classifier_assert.svh
`ifndef RAY_SEGMENT_PIXEL_CLASSIFIER_ASSERT_SVH
`define RAY_SEGMENT_PIXEL_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSPC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rspc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RSPC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rspc assertion failed");

`endif

>>> design/rspc_pkg.sv
package rspc_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int CELL_W       = 16;
  localparam int POS_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [POS_W-1:0] PIXEL_W_RESET = 32'h0001_0000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] KIND_CELL      = 2'd0;
  localparam logic [1:0] KIND_BOUNDARY  = 2'd1;
  localparam logic [1:0] KIND_UNDEF_BND = 2'd2;
  localparam logic [1:0] KIND_EMPTY     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_UNDEF_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_W  = 1'd1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CELL_W-1:0] cell_id;
    logic [POS_W-1:0]  segment_length;
    logic [POS_W-1:0]  pixel_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [CELL_W-1:0] result_cell;
    logic              beyond_track;
    logic              table_overflowed;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start_query;
    logic walk;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic few_segs;
    logic walk_done;
  } status_t;

endpackage

>>> design/ray_segment_pixel_classifier.sv
// Segment items (start, append, unused code) are accepted back to back.
// A query over a ray of n stored segments walks the inner boundaries, one RAM read per
// cycle, until an entry decides or the last one is read; for n <= 1 there is no walk.
// The next item is accepted once the result has moved to the output register.
// Reset (rst_n low, synchronous) clears segment count, overflow flag, output valid and
// sets undefined_cell_id = 0, pixel_width = 1.0; segment memories are not cleared.
`include "ray_segment_pixel_classifier_assert.svh"

module ray_segment_pixel_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rspc_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rspc_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rspc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rspc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rspc_pkg::*;

  cmd_t    ctl_cmd;
  status_t dp_status;

  assign cfg_ready = 1'b1;

  rspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.operation),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (dp_status),
    .cmd       (ctl_cmd)
  );

  rspc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .status    (dp_status),
    .in_item   (in_item),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

  `RSPC_ASSERT_NXT(a_query_busy, in_valid && in_ready && (in_item.operation == OP_QUERY), !in_ready)
  `RSPC_ASSERT_IMP(a_push_free, ctl_cmd.push, !out_valid || out_ready)
  `RSPC_ASSERT_IMP(a_done_in_walk, dp_status.walk_done, ctl_cmd.walk)
  `RSPC_ASSERT_NXT(a_push_shows, ctl_cmd.push, out_valid)

endmodule

>>> design/rspc_ram.sv
module rspc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/rspc_ctrl.sv
module rspc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  rspc_pkg::status_t status,
  output rspc_pkg::cmd_t   cmd
);
  import rspc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.start_query = 1'b1;
            state_nxt       = status.few_segs ? ST_PUSH : ST_WALK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.push | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/rspc_datapath.sv
module rspc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rspc_pkg::cmd_t                      cmd,
  output rspc_pkg::status_t                   status,
  input  rspc_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [rspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rspc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rspc_pkg::out_item_t                 out_item
);
  import rspc_pkg::*;

  logic [CELL_W-1:0]    undef_id_r;
  logic [POS_W-1:0]     pix_w_r;

  logic [SEG_CNT_W-1:0] cnt_r, cnt_nxt, cnt_m1;
  logic                 ovf_r, ovf_nxt;
  logic [CELL_W-1:0]    last_cell_r, last_cell_nxt;
  logic [POS_W-1:0]     last_end_r, last_end_nxt;
  logic [SEG_IDX_W-1:0] last_idx;

  logic                 we;
  logic [SEG_IDX_W-1:0] waddr;
  logic [POS_W-1:0]     wend;
  logic [POS_W:0]       sum_ext;
  logic [POS_W-1:0]     sat_sum;
  logic                 is_start;

  logic [SEG_IDX_W-1:0] rd_addr_r, rd_idx_r;
  logic                 rd_valid_r;
  logic [CELL_W-1:0]    ram_cell, p_cell_r;
  logic [POS_W-1:0]     ram_end, p_end_r, pos_r;

  logic [1:0]           res_kind_r;
  logic [CELL_W-1:0]    res_cell_r;
  logic                 res_beyond_r;
  out_item_t            out_r;

  logic signed [POS_W:0]   diff;
  logic signed [POS_W+1:0] twice_d, w_s;
  logic                    in_band, past, decide;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undef_id_r <= '0;
      pix_w_r    <= PIXEL_W_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNDEF_ID: undef_id_r <= cfg_data[CELL_W-1:0];
        REG_PIXEL_W:  pix_w_r    <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // segment loading
  assign cnt_m1   = cnt_r - SEG_CNT_W'(1);
  assign last_idx = cnt_m1[SEG_IDX_W-1:0];
  assign sum_ext  = {1'b0, last_end_r} + {1'b0, in_item.segment_length};
  assign sat_sum  = sum_ext[POS_W] ? '1 : sum_ext[POS_W-1:0];
  assign is_start = (in_item.operation == OP_START) ||
                    ((in_item.operation == OP_APPEND) && (cnt_r == '0));

  always_comb begin
    we            = 1'b0;
    waddr         = '0;
    wend          = in_item.segment_length;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    last_cell_nxt = last_cell_r;
    last_end_nxt  = last_end_r;
    if (cmd.load) begin
      if (is_start) begin
        we            = 1'b1;
        cnt_nxt       = SEG_CNT_W'(1);
        ovf_nxt       = 1'b0;
        last_cell_nxt = in_item.cell_id;
        last_end_nxt  = in_item.segment_length;
      end else if ((in_item.operation == OP_APPEND) && !ovf_r) begin
        if (last_cell_r == in_item.cell_id) begin
          we           = 1'b1;
          waddr        = last_idx;
          wend         = sat_sum;
          last_end_nxt = sat_sum;
        end else if (cnt_r < SEG_CNT_W'(MAX_SEGMENTS)) begin
          we            = 1'b1;
          waddr         = cnt_r[SEG_IDX_W-1:0];
          wend          = sat_sum;
          cnt_nxt       = cnt_r + SEG_CNT_W'(1);
          last_cell_nxt = in_item.cell_id;
          last_end_nxt  = sat_sum;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_cell_r <= last_cell_nxt;
    last_end_r  <= last_end_nxt;
  end

  rspc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_SEGMENTS)) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.cell_id),
    .raddr (rd_addr_r),
    .rdata (ram_cell)
  );

  rspc_ram #(.WIDTH(POS_W), .DEPTH(MAX_SEGMENTS)) u_ends (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wend),
    .raddr (rd_addr_r),
    .rdata (ram_end)
  );

  // boundary test on entry rd_idx_r-1, right neighbor from the RAM
  assign diff    = $signed({1'b0, p_end_r}) - $signed({1'b0, pos_r});
  assign twice_d = {diff, 1'b0};
  assign w_s     = $signed({2'b00, pix_w_r});
  assign in_band = (twice_d > -w_s) && (twice_d <= w_s);
  assign past    = twice_d > w_s;
  assign decide  = rd_valid_r && (rd_idx_r != '0) && (in_band || past);

  assign status.few_segs  = cnt_r <= SEG_CNT_W'(1);
  assign status.walk_done = rd_valid_r && (decide || (rd_idx_r == last_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (cmd.walk) begin
      rd_valid_r <= !status.walk_done;
    end else begin
      rd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      rd_addr_r <= '0;
      pos_r     <= in_item.pixel_position;
      if (cnt_r == '0) begin
        res_kind_r   <= KIND_EMPTY;
        res_cell_r   <= '0;
        res_beyond_r <= 1'b0;
      end else begin
        res_kind_r   <= KIND_CELL;
        res_cell_r   <= last_cell_r;
        res_beyond_r <= in_item.pixel_position > last_end_r;
      end
    end else if (cmd.walk) begin
      rd_addr_r <= rd_addr_r + SEG_IDX_W'(1);
      rd_idx_r  <= rd_addr_r;
      if (decide) begin
        res_beyond_r <= 1'b0;
        if (in_band) begin
          res_cell_r <= '0;
          res_kind_r <= ((p_cell_r == undef_id_r) || (ram_cell == undef_id_r)) ?
                        KIND_UNDEF_BND : KIND_BOUNDARY;
        end else begin
          res_cell_r <= p_cell_r;
          res_kind_r <= KIND_CELL;
        end
      end
    end
    if (rd_valid_r) begin
      p_cell_r <= ram_cell;
      p_end_r  <= ram_end;
    end
    if (cmd.push) begin
      out_r.result_kind      <= res_kind_r;
      out_r.result_cell      <= res_cell_r;
      out_r.beyond_track     <= res_beyond_r;
      out_r.table_overflowed <= ovf_r;
    end
  end

  assign out_item = out_r;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rspc_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         LONG_HOLD     = 400;

  class pixel_class_scoreboard;
    bit [CELL_W-1:0] cell_of [MAX_SEGMENTS];
    bit [POS_W-1:0]  end_of  [MAX_SEGMENTS];
    int unsigned     n_segs = 0;
    bit              dropped = 1'b0;
    bit [CELL_W-1:0] undef_id = '0;
    bit [POS_W-1:0]  pix_w = PIXEL_W_RESET;
    out_item_t       pixel_answers_q[$];
    int unsigned     n_results = 0;
    int unsigned     n_errors = 0;

    task report(string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_UNDEF_ID: undef_id = val[CELL_W-1:0];
        REG_PIXEL_W:  pix_w = val[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [POS_W-1:0] sat_sum(bit [POS_W-1:0] a, bit [POS_W-1:0] b);
      bit [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? '1 : s[POS_W-1:0];
    endfunction

    function void start_ray(bit [CELL_W-1:0] id, bit [POS_W-1:0] len);
      cell_of[0] = id;
      end_of[0]  = len;
      n_segs     = 1;
      dropped    = 1'b0;
    endfunction

    // track the ray as the block stores it; queries queue their answer
    function void note_item(in_item_t it);
      out_item_t   ans;
      longint      w, e, p, twice_d;
      bit          decided;
      int unsigned last;
      int          i;
      ans     = '0;
      decided = 1'b0;
      w       = pix_w;
      p       = it.pixel_position;
      case (it.operation)
        OP_START: start_ray(it.cell_id, it.segment_length);
        OP_APPEND: begin
          if (n_segs == 0) begin
            start_ray(it.cell_id, it.segment_length);
          end else if (!dropped) begin
            last = n_segs - 1;
            if (cell_of[last] == it.cell_id) begin
              end_of[last] = sat_sum(end_of[last], it.segment_length);
            end else if (n_segs < MAX_SEGMENTS) begin
              cell_of[n_segs] = it.cell_id;
              end_of[n_segs]  = sat_sum(end_of[last], it.segment_length);
              n_segs++;
            end else begin
              dropped = 1'b1;
            end
          end
        end
        OP_QUERY: begin
          if (n_segs == 0) begin
            ans.result_kind = KIND_EMPTY;
            decided = 1'b1;
          end
          for (i = 0; !decided && i + 1 < n_segs; i++) begin
            e = end_of[i];
            twice_d = 2 * (e - p);
            if (twice_d > -w && twice_d <= w) begin
              ans.result_kind = (cell_of[i] == undef_id || cell_of[i+1] == undef_id) ?
                                KIND_UNDEF_BND : KIND_BOUNDARY;
              decided = 1'b1;
            end else if (twice_d > w) begin
              ans.result_kind = KIND_CELL;
              ans.result_cell = cell_of[i];
              decided = 1'b1;
            end
          end
          if (!decided) begin
            ans.result_kind  = KIND_CELL;
            ans.result_cell  = cell_of[n_segs-1];
            ans.beyond_track = it.pixel_position > end_of[n_segs-1];
          end
          ans.table_overflowed = dropped;
          pixel_answers_q = {pixel_answers_q, ans};
        end
        default: ;
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (pixel_answers_q.size() == 0) begin
        report($sformatf("result 0x%h with no query waiting", got));
        return;
      end
      want = pixel_answers_q.pop_front();
      if (got.result_kind !== want.result_kind) begin
        report($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
      end
      if (got.result_cell !== want.result_cell) begin
        report($sformatf("result_cell 0x%h, want 0x%h", got.result_cell, want.result_cell));
      end
      if (got.beyond_track !== want.beyond_track) begin
        report($sformatf("beyond_track %b, want %b", got.beyond_track, want.beyond_track));
      end
      if (got.table_overflowed !== want.table_overflowed) begin
        report($sformatf("table_overflowed %b, want %b",
                         got.table_overflowed, want.table_overflowed));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    calm = 1'b0;
  bit                    long_hold_done = 1'b0;

  pixel_class_scoreboard sb = new;

  ray_segment_pixel_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // handshakes are sampled at the falling edge, where every signal is settled
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_item);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!long_hold_done && sb.n_results >= 60) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_op(logic [1:0] op, logic [CELL_W-1:0] id,
                         logic [POS_W-1:0] len, logic [POS_W-1:0] pos);
    in_item_t it;
    it = {op, id, len, pos};
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(negedge clk); while (!in_ready);
    sb.note_item(it);
    @(posedge clk);
  endtask

  task automatic wait_quiet(int unsigned extra);
    while (sb.pixel_answers_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(logic [CELL_W-1:0] id, logic [POS_W-1:0] pw);
    logic [CFG_DATA_W-1:0] id_word;
    id_word = {16'($urandom), id};
    cfg_valid <= 1'b1;
    cfg_index <= REG_UNDEF_ID;
    cfg_data  <= id_word;
    do @(negedge clk); while (!cfg_ready);
    sb.set_reg(REG_UNDEF_ID, id_word);
    @(posedge clk);
    cfg_index <= REG_PIXEL_W;
    cfg_data  <= pw;
    do @(negedge clk); while (!cfg_ready);
    sb.set_reg(REG_PIXEL_W, pw);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_len();
    logic [POS_W-1:0] span;
    if (sb.pix_w == '0) begin
      span = 32'h0003_0000;
    end else if (sb.pix_w > 32'h1000_0000) begin
      span = 32'h1000_0000;
    end else begin
      span = {sb.pix_w[30:0], 1'b0};
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1, span);
    endcase
  endfunction

  // mostly positions around a stored end, within and just outside half a pixel
  function automatic logic [POS_W-1:0] pick_pos();
    longint b, half, hs, r, p;
    if (sb.n_segs == 0 || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        default: return $urandom;
      endcase
    end
    b    = sb.end_of[$urandom_range(0, sb.n_segs - 1)];
    half = sb.pix_w / 2;
    hs   = half + 2;
    if (hs > 64'h7FFF_0000) hs = 64'h7FFF_0000;
    case ($urandom_range(0, 5))
      0: p = b - half;
      1: p = b + half;
      2: p = b + half + 1;
      3: p = b - half - 1;
      default: begin
        r = $urandom_range(0, 32'(2 * hs));
        p = b - hs + r;
      end
    endcase
    if (p < 0) p = 0;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    return p[POS_W-1:0];
  endfunction

  task automatic run_rays(int unsigned n_items, int unsigned pause_at);
    int unsigned     sent, n_seg, n_q, k;
    bit              long_ray;
    bit [CELL_W-1:0] pool [4];
    sent = 0;
    while (sent < n_items) begin
      if (pause_at != 0 && sent >= pause_at) begin
        in_valid <= 1'b0;
        wait_quiet(0);
        pause_at = 0;
      end
      pool[0] = sb.undef_id;
      for (k = 1; k < 4; k++) pool[k] = 16'($urandom);
      long_ray = ($urandom_range(0, 7) == 0);
      n_seg = long_ray ? $urandom_range(60, 72) : $urandom_range(1, 8);
      for (k = 0; k < n_seg; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_op(OP_UNUSED, 16'($urandom), $urandom, $urandom);
        end else if ($urandom_range(0, 19) == 0) begin
          send_op(OP_QUERY, 16'($urandom), $urandom, pick_pos());
          sent++;
        end
        // an opening append continues whatever ray is stored
        send_op((k == 0 && $urandom_range(0, 5) != 0) ? OP_START : OP_APPEND,
                (long_ray && $urandom_range(0, 7) != 0) ? 16'($urandom)
                                                        : pool[$urandom_range(0, 3)],
                pick_len(), $urandom);
        sent++;
      end
      n_q = $urandom_range(1, 6);
      for (k = 0; k < n_q; k++) begin
        send_op(OP_QUERY, 16'($urandom), $urandom, pick_pos());
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: undefined id 0, pixel width 1.0
    send_op(OP_QUERY,  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_APPEND, 16'h0005, 32'h0001_0000, 32'hFFFF_FFFF);
    send_op(OP_APPEND, 16'h0005, 32'h0000_8000, 32'h0000_0000);
    send_op(OP_APPEND, 16'h0000, 32'h0002_0000, 32'h0000_0000);
    send_op(OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_APPEND, 16'h1234, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0001_8000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0001_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0002_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0003_8000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0004_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_START,  16'hFFFF, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_APPEND, 16'h0001, 32'h0000_0001, 32'h0000_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_START,  16'hABCD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'h0000_8000);
    send_op(OP_QUERY,  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    wait_quiet(SETTLE_CYCLES);

    write_config(16'($urandom), 32'h0000_0000);
    run_rays(160, 0);
    wait_quiet(SETTLE_CYCLES);

    write_config(16'hFFFF, 32'hFFFF_FFFF);
    run_rays(160, 70);
    wait_quiet(SETTLE_CYCLES);

    write_config(16'($urandom), $urandom_range(1, 32'h0004_0000));
    run_rays(160, 0);
    wait_quiet(SETTLE_CYCLES);

    calm = 1'b1;
    write_config(16'h0000, PIXEL_W_RESET);
    run_rays(170, 0);
    wait_quiet(SETTLE_CYCLES);

    if (sb.n_errors == 0) begin
      $display("** ray_segment_pixel_classifier: PASSED **");
    end else begin
      $display("** ray_segment_pixel_classifier: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** ray_segment_pixel_classifier: FAILED **");
    $finish;
  end

endmodule
